/* rtl/rtd_pkg.sv */
// Shared types, constants and fixed-point helpers for the radial/tangential
// distortion pipeline. No dependencies.
`default_nettype none
package rtd_pkg;

  // Internal values: signed Q.24, clamped to +-(2^40 - 1), with a saturation mark.
  localparam int FX_MAG = 40;
  localparam int FX_W   = FX_MAG + 1;

  localparam logic signed [FX_W-1:0] WIDE_MAX = 41'sd1099511627775;
  localparam logic signed [FX_W:0]   WIDE_MAX_EXT = 42'sd1099511627775;
  localparam logic signed [FX_W-1:0] Q24_ONE  = 41'sd16777216;

  // Divider: 4 quotient bits per stage, 10 stages, plus prep and final registers.
  localparam int DIV_BPS   = 4;
  localparam int DIV_STEPS = FX_MAG / DIV_BPS;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  // Stages after the divider: 16 datapath registers plus the output register.
  localparam int POST_STAGES = 16;
  localparam int PIPE_LAT    = DIV_LAT + POST_STAGES + 1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZBAD = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef enum logic [2:0] {
    REG_K1 = 3'd0,
    REG_K2 = 3'd1,
    REG_K3 = 3'd2,
    REG_P1 = 3'd3,
    REG_P2 = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                   sat;
    logic signed [FX_W-1:0] v;
  } fx_t;

  typedef struct packed {
    logic signed [31:0] pt_x;
    logic signed [31:0] pt_y;
    logic signed [31:0] pt_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] dist_x;
    logic signed [31:0] dist_y;
    logic [1:0]         status;
  } out_t;

  function automatic fx_t fx_mk(logic signed [31:0] k);
    fx_t r;
    r.sat = 1'b0;
    r.v   = FX_W'(k);
    return r;
  endfunction

  // Exact add, then clamp; marks propagate.
  function automatic fx_t fx_add(fx_t a, fx_t b);
    logic signed [FX_W:0] s;
    fx_t r;
    s     = (FX_W+1)'(a.v) + (FX_W+1)'(b.v);
    r.sat = a.sat | b.sat;
    if (s > WIDE_MAX_EXT) begin
      r.v   = WIDE_MAX;
      r.sat = 1'b1;
    end else if (s < -WIDE_MAX_EXT) begin
      r.v   = -WIDE_MAX;
      r.sat = 1'b1;
    end else begin
      r.v = s[FX_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/rtd_mul.sv */
// Two-stage Q.24 multiplier with round-half-away and clamp.
// Depends on rtd_pkg.
`default_nettype none
module rtd_mul (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire rtd_pkg::fx_t a_i,
  input  wire rtd_pkg::fx_t b_i,
  output rtd_pkg::fx_t      p_o
);
  localparam int MW = rtd_pkg::FX_MAG;
  localparam int HW = MW / 2;

  logic [rtd_pkg::FX_W-1:0] a_abs, b_abs;
  logic [MW+HW-1:0]         pp_lo_d, pp_hi_d, pp_lo_q, pp_hi_q;
  logic                     neg_q, zero_q, sat_q;
  logic [2*MW-1:0]          prod;
  logic [2*MW-25:0]         mag_full;
  logic [MW-1:0]            mag;
  logic                     ovf;
  rtd_pkg::fx_t             p_d, p_q;

  // stage 1: split |b| into two halves, two 40x20 partial products
  always_comb begin
    a_abs   = a_i.v[rtd_pkg::FX_W-1] ? -a_i.v : a_i.v;
    b_abs   = b_i.v[rtd_pkg::FX_W-1] ? -b_i.v : b_i.v;
    pp_lo_d = a_abs[MW-1:0] * b_abs[HW-1:0];
    pp_hi_d = a_abs[MW-1:0] * b_abs[MW-1:HW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d;
      neg_q   <= a_i.v[rtd_pkg::FX_W-1] ^ b_i.v[rtd_pkg::FX_W-1];
      zero_q  <= (a_i.v == '0) || (b_i.v == '0);
      sat_q   <= a_i.sat | b_i.sat;
    end
  end

  // stage 2: sum, round at bit 23, clamp, restore sign
  always_comb begin
    prod     = {pp_hi_q, {HW{1'b0}}} + (2*MW)'(pp_lo_q) + (2*MW)'(24'h800000);
    mag_full = prod[2*MW-1:24];
    ovf      = mag_full > (2*MW-24)'(rtd_pkg::WIDE_MAX);
    mag      = ovf ? rtd_pkg::WIDE_MAX[MW-1:0] : mag_full[MW-1:0];
    if (zero_q) begin
      p_d.v   = '0;
      p_d.sat = 1'b0;
    end else begin
      p_d.v   = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      p_d.sat = sat_q | ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

/* rtl/rtd_div.sv */
// Pipelined restoring divider: Q16.16 / Q16.16 -> Q.24, rounded half away.
// Depends on rtd_pkg.
`default_nettype none
module rtd_div (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic        [31:0] den_i,
  output rtd_pkg::fx_t            q_o
);
  localparam int MW = rtd_pkg::FX_MAG;
  localparam int NS = rtd_pkg::DIV_STEPS;

  logic [30:0]   rem_q [0:NS];
  logic [MW-1:0] low_q [0:NS];
  logic [MW-1:0] quo_q [0:NS];
  logic [30:0]   ud_q  [0:NS];
  logic          neg_q [0:NS];
  logic          ovf_q [0:NS];

  logic [31:0]      un;
  logic [30:0]      ud;
  logic [MW+15:0]   nw;
  rtd_pkg::fx_t     q_d, q_q;
  logic [MW-1:0]    mag;

  // prep: numerator scaled by 2^24 plus half the divisor; top bits decide overflow
  always_comb begin
    un = num_i[31] ? 32'(-num_i) : 32'(num_i);
    ud = den_i[30:0];
    nw = {un, 24'h0} + (MW+16)'(ud >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= 31'(nw[MW+15:MW]);
      low_q[0] <= nw[MW-1:0];
      quo_q[0] <= '0;
      ud_q[0]  <= ud;
      neg_q[0] <= num_i[31];
      ovf_q[0] <= {15'h0, nw[MW+15:MW]} >= ud;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [30:0]   rem;
    logic [MW-1:0] low;
    logic [MW-1:0] quo;
    logic [31:0]   trial;

    always_comb begin
      rem = rem_q[k-1];
      low = low_q[k-1];
      quo = quo_q[k-1];
      for (int j = 0; j < rtd_pkg::DIV_BPS; j++) begin
        trial = {rem, low[MW-1]};
        low   = {low[MW-2:0], 1'b0};
        if (trial >= {1'b0, ud_q[k-1]}) begin
          rem = 31'(trial - {1'b0, ud_q[k-1]});
          quo = {quo[MW-2:0], 1'b1};
        end else begin
          rem = trial[30:0];
          quo = {quo[MW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem;
        low_q[k] <= low;
        quo_q[k] <= quo;
        ud_q[k]  <= ud_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  always_comb begin
    mag     = ovf_q[NS] ? rtd_pkg::WIDE_MAX[MW-1:0] : quo_q[NS];
    q_d.sat = ovf_q[NS];
    q_d.v   = neg_q[NS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule
`default_nettype wire

/* rtl/radial_tangential_distort.sv */
// Top level: radial/tangential lens distortion of one 3-D point per word.
// Depends on rtd_pkg, rtd_div, rtd_mul.
`default_nettype none
// Channel  Direction  Handshake                    Word
// in       sink       in_valid_i / in_stall_o      rtd_pkg::in_t  (pt_x, pt_y, pt_z)
// out      source     out_valid_o / out_stall_i    rtd_pkg::out_t (dist_x, dist_y, status)
// cfg      sink       cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// One word enters per cycle while the output is not stalled; each result passes
// the divider (4 quotient bits per stage), then 16 stages of multipliers and
// clamped adds, then the output register.
// Reset clears the valid bits and the coefficients; payload registers are not reset.
// A stall on a valid output word freezes the whole pipeline and raises the input stall.
module radial_tangential_distort (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire rtd_pkg::in_t  in_word_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output rtd_pkg::out_t      out_word_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [2:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i
);
  localparam int DL  = rtd_pkg::DIV_LAT;
  localparam int NP  = rtd_pkg::POST_STAGES;
  localparam int LAT = rtd_pkg::PIPE_LAT;

  // per-stage state after the divider; each stage fills in what it computes
  typedef struct packed {
    logic         zbad;
    rtd_pkg::fx_t x, y, xy, r2, xx2, yy2, sx, sy, r4, t0, tx, ty;
    rtd_pkg::fx_t p2sx, p1sy, t1, r6, t, dx1, dy1;
  } stg_t;

  logic               pipe_en;
  logic [LAT-1:0]     vld_q;
  logic [DL-1:0]      zb_q;
  logic signed [31:0] k1_q, k2_q, k3_q, p1_q, p2_q;
  rtd_pkg::fx_t       k1, k2, k3, p1, p2;
  rtd_pkg::fx_t       div_x, div_y;
  stg_t               s_d [0:NP-1];
  stg_t               p_q [0:NP-1];
  rtd_pkg::fx_t       m_xx, m_yy, m_xy, m_r4, m_k1r2, m_p1xy, m_p2xy;
  rtd_pkg::fx_t       m_p2sx, m_p1sy, m_r6, m_k2r4, m_k3r6, m_dx0, m_dy0;
  rtd_pkg::fx_t       dx, dy;
  rtd_pkg::out_t      out_d, out_q;
  logic               sat_any;

  // global advance: everything moves unless a finished word is held
  assign pipe_en     = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !pipe_en;
  assign cfg_ready_o = 1'b1;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q <= '0;
      k2_q <= '0;
      k3_q <= '0;
      p1_q <= '0;
      p2_q <= '0;
    end else if (cfg_valid_i) begin
      case (rtd_pkg::cfg_idx_e'(cfg_index_i))
        rtd_pkg::REG_K1: k1_q <= cfg_data_i;
        rtd_pkg::REG_K2: k2_q <= cfg_data_i;
        rtd_pkg::REG_K3: k3_q <= cfg_data_i;
        rtd_pkg::REG_P1: p1_q <= cfg_data_i;
        rtd_pkg::REG_P2: p2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign k1 = rtd_pkg::fx_mk(k1_q);
  assign k2 = rtd_pkg::fx_mk(k2_q);
  assign k3 = rtd_pkg::fx_mk(k3_q);
  assign p1 = rtd_pkg::fx_mk(p1_q);
  assign p2 = rtd_pkg::fx_mk(p2_q);

  // valid bits travel alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // depth check rides next to the divider
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      zb_q <= {zb_q[DL-2:0], (in_word_i.pt_z <= 32'sd0)};
    end
  end

  // x = X/Z, y = Y/Z
  rtd_div u_div_x (
    .clk_i (clk_i), .en_i (pipe_en),
    .num_i (in_word_i.pt_x), .den_i (in_word_i.pt_z), .q_o (div_x)
  );
  rtd_div u_div_y (
    .clk_i (clk_i), .en_i (pipe_en),
    .num_i (in_word_i.pt_y), .den_i (in_word_i.pt_z), .q_o (div_y)
  );

  // multipliers launched from p_q[i] land for s_d[i+3]
  rtd_mul u_xx   (.clk_i(clk_i), .en_i(pipe_en), .a_i(p_q[0].x),  .b_i(p_q[0].x),  .p_o(m_xx));
  rtd_mul u_yy   (.clk_i(clk_i), .en_i(pipe_en), .a_i(p_q[0].y),  .b_i(p_q[0].y),  .p_o(m_yy));
  rtd_mul u_xy   (.clk_i(clk_i), .en_i(pipe_en), .a_i(p_q[0].x),  .b_i(p_q[0].y),  .p_o(m_xy));
  rtd_mul u_r4   (.clk_i(clk_i), .en_i(pipe_en), .a_i(p_q[3].r2), .b_i(p_q[3].r2), .p_o(m_r4));
  rtd_mul u_k1r2 (.clk_i(clk_i), .en_i(pipe_en), .a_i(k1),        .b_i(p_q[3].r2), .p_o(m_k1r2));
  rtd_mul u_p1xy (.clk_i(clk_i), .en_i(pipe_en), .a_i(p1),        .b_i(p_q[3].xy), .p_o(m_p1xy));
  rtd_mul u_p2xy (.clk_i(clk_i), .en_i(pipe_en), .a_i(p2),        .b_i(p_q[3].xy), .p_o(m_p2xy));
  rtd_mul u_p2sx (.clk_i(clk_i), .en_i(pipe_en), .a_i(p2),        .b_i(p_q[4].sx), .p_o(m_p2sx));
  rtd_mul u_p1sy (.clk_i(clk_i), .en_i(pipe_en), .a_i(p1),        .b_i(p_q[4].sy), .p_o(m_p1sy));
  rtd_mul u_r6   (.clk_i(clk_i), .en_i(pipe_en), .a_i(p_q[6].r2), .b_i(p_q[6].r4), .p_o(m_r6));
  rtd_mul u_k2r4 (.clk_i(clk_i), .en_i(pipe_en), .a_i(k2),        .b_i(p_q[6].r4), .p_o(m_k2r4));
  rtd_mul u_k3r6 (.clk_i(clk_i), .en_i(pipe_en), .a_i(k3),        .b_i(p_q[9].r6), .p_o(m_k3r6));
  rtd_mul u_dx0  (.clk_i(clk_i), .en_i(pipe_en), .a_i(p_q[12].x), .b_i(p_q[12].t), .p_o(m_dx0));
  rtd_mul u_dy0  (.clk_i(clk_i), .en_i(pipe_en), .a_i(p_q[12].y), .b_i(p_q[12].t), .p_o(m_dy0));

  always_comb begin
    s_d[0]      = '0;
    s_d[0].zbad = zb_q[DL-1];
    s_d[0].x    = div_x;
    s_d[0].y    = div_y;
    for (int i = 1; i < NP; i++) begin
      s_d[i] = p_q[i-1];
    end
    // r2 and the doubled squares
    s_d[3].xy   = m_xy;
    s_d[3].r2   = rtd_pkg::fx_add(m_xx, m_yy);
    s_d[3].xx2  = rtd_pkg::fx_add(m_xx, m_xx);
    s_d[3].yy2  = rtd_pkg::fx_add(m_yy, m_yy);
    // r2 + 2x^2, r2 + 2y^2
    s_d[4].sx   = rtd_pkg::fx_add(p_q[3].r2, p_q[3].xx2);
    s_d[4].sy   = rtd_pkg::fx_add(p_q[3].r2, p_q[3].yy2);
    // start of radial factor, doubled tangential cross terms
    s_d[6].r4   = m_r4;
    s_d[6].t0   = rtd_pkg::fx_add('{sat: 1'b0, v: rtd_pkg::Q24_ONE}, m_k1r2);
    s_d[6].tx   = rtd_pkg::fx_add(m_p1xy, m_p1xy);
    s_d[6].ty   = rtd_pkg::fx_add(m_p2xy, m_p2xy);
    s_d[7].p2sx = m_p2sx;
    s_d[7].p1sy = m_p1sy;
    s_d[9].r6   = m_r6;
    s_d[9].t1   = rtd_pkg::fx_add(p_q[8].t0, m_k2r4);
    s_d[12].t   = rtd_pkg::fx_add(p_q[11].t1, m_k3r6);
    s_d[15].dx1 = rtd_pkg::fx_add(m_dx0, p_q[14].tx);
    s_d[15].dy1 = rtd_pkg::fx_add(m_dy0, p_q[14].p1sy);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < NP; i++) begin
        p_q[i] <= s_d[i];
      end
    end
  end

  // last adds, clamp to 32 bits, status
  always_comb begin
    dx      = rtd_pkg::fx_add(p_q[NP-1].dx1, p_q[NP-1].p2sx);
    dy      = rtd_pkg::fx_add(p_q[NP-1].dy1, p_q[NP-1].ty);
    sat_any = dx.sat | dy.sat;
    if (dx.v > 41'sd2147483647) begin
      out_d.dist_x = 32'sh7FFFFFFF;
      sat_any      = 1'b1;
    end else if (dx.v < -41'sd2147483648) begin
      out_d.dist_x = 32'sh80000000;
      sat_any      = 1'b1;
    end else begin
      out_d.dist_x = dx.v[31:0];
    end
    if (dy.v > 41'sd2147483647) begin
      out_d.dist_y = 32'sh7FFFFFFF;
      sat_any      = 1'b1;
    end else if (dy.v < -41'sd2147483648) begin
      out_d.dist_y = 32'sh80000000;
      sat_any      = 1'b1;
    end else begin
      out_d.dist_y = dy.v[31:0];
    end
    out_d.status = sat_any ? rtd_pkg::ST_SAT : rtd_pkg::ST_OK;
    if (p_q[NP-1].zbad) begin
      out_d.dist_x = '0;
      out_d.dist_y = '0;
      out_d.status = rtd_pkg::ST_ZBAD;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign out_word_o  = out_q;

  // bad depth always yields zero coordinates
  a_zbad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == rtd_pkg::ST_ZBAD)
      |-> (out_word_o.dist_x == '0) && (out_word_o.dist_y == '0))
    else $error("bad-depth word with nonzero coordinates");

  // a held output word must back-pressure the input
  a_stall_prop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input not stalled while output held");

  // frozen pipeline keeps every valid bit
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(vld_q))
    else $error("valid bits moved during stall");

endmodule
`default_nettype wire
